// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// File: hw/rtl/lpc_pkg.sv
package lpc_pkg;

	// Default number of fraction bits of the clock format.
	localparam int unsigned CLOCK_FRAC_BITS_DEF = 16;

	// Field widths.
	localparam int unsigned SPEED_W    = 16;
	localparam int unsigned SPEED_FRAC = 8;
	localparam int unsigned DUR_W      = 31;
	localparam int unsigned LIM_W      = 16;
	localparam int unsigned DT_W       = 24;
	localparam int unsigned CLK_W      = 32;
	localparam int unsigned CFG_DATA_W = 31;
	localparam int unsigned CFG_IDX_W  = 2;

	// Width of the shared adder; wide enough for clock minus a 63-bit product.
	localparam int unsigned ALU_W = 65;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED           = 2'd0,
		REG_LOOP_DURATION   = 2'd1,
		REG_ITERATION_LIMIT = 2'd2
	} cfg_reg_t;

	// Configuration as seen by the sequencer; dur is never zero.
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic [DUR_W-1:0]   dur;
		logic [LIM_W-1:0]   lim;
	} cfg_t;

	// One operation of the shared adder: a + (inv ? ~b : b) + cin.
	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             inv;
		logic             cin;
	} alu_op_t;

	// Sequencer status toward the top level.
	typedef struct packed {
		logic idle;
		logic done;
	} seq_status_t;

	// Saturate a wide two's-complement value to the signed 32-bit range.
	function automatic logic [CLK_W-1:0] sat32(input logic [ALU_W-1:0] v);
		logic [CLK_W-1:0] r;
		if (v[ALU_W-1:CLK_W-1] == {(ALU_W-CLK_W+1){v[ALU_W-1]}}) begin
			r = v[CLK_W-1:0];
		end else if (v[ALU_W-1]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7FFF_FFFF;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/lpc_alu.sv
module lpc_alu (
	input  lpc_pkg::alu_op_t         op,
	output logic [lpc_pkg::ALU_W-1:0] sum
);

	// Single add/subtract unit shared by the arithmetic steps of the sequencer.
	assign sum = op.a + (op.inv ? ~op.b : op.b) + {{(lpc_pkg::ALU_W-1){1'b0}}, op.cin};

endmodule

// File: hw/rtl/lpc_seq.sv
module lpc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lpc_pkg::DT_W-1:0]    tick_delta,
	input  lpc_pkg::cfg_t               cfg,
	input  logic                        taken,
	output lpc_pkg::seq_status_t        status,
	output logic [lpc_pkg::CLK_W-1:0]   clock,
	output logic [lpc_pkg::CLK_W-1:0]   iteration
);

	localparam int unsigned DivSteps = 32;
	localparam int unsigned MulSteps = lpc_pkg::DUR_W;
	localparam int unsigned ProdW    = lpc_pkg::SPEED_W + lpc_pkg::DT_W;
	localparam int unsigned IdxW     = lpc_pkg::CLK_W + 2;
	localparam int unsigned AccW     = lpc_pkg::CLK_W + lpc_pkg::DUR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_ADV, S_ABS, S_DIV, S_ITER, S_CLAMP, S_REM,
		S_JDIFF, S_JABS, S_MULT, S_FIN, S_DONE
	} state_t;

	state_t                      state_q;
	logic [lpc_pkg::CLK_W-1:0]   clock_q;
	logic [lpc_pkg::CLK_W-1:0]   iter_q;
	logic [4:0]                  cnt_q;

	logic [ProdW-1:0]            prod_q;
	logic [lpc_pkg::CLK_W-1:0]   dividend_q;
	logic [lpc_pkg::DUR_W-1:0]   rem_q;
	logic                        neg_q;
	logic [IdxW-1:0]             idx_q;
	logic [lpc_pkg::CLK_W-1:0]   inew_q;
	logic [lpc_pkg::CLK_W:0]     j_q;
	logic                        jneg_q;
	logic [AccW-1:0]             mcand_q;
	logic [lpc_pkg::DUR_W-1:0]   mplier_q;
	logic [AccW-1:0]             acc_q;

	logic signed [ProdW:0]       prod_c;
	lpc_pkg::alu_op_t            op;
	logic [lpc_pkg::ALU_W-1:0]   alu_sum;
	logic [lpc_pkg::CLK_W-1:0]   inew_c;
	logic                        mod_c;
	logic                        div_ok;

	// Step product of speed and elapsed time, registered before use.
	assign prod_c = $signed(cfg.speed) * $signed({1'b0, tick_delta});

	// Operand selection for the shared adder, one operation per state.
	always_comb begin
		op = '0;
		case (state_q)
			S_ADV: begin
				op.a = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){clock_q[lpc_pkg::CLK_W-1]}}, clock_q};
				op.b = {{(lpc_pkg::ALU_W-ProdW+lpc_pkg::SPEED_FRAC){prod_q[ProdW-1]}},
					prod_q[ProdW-1:lpc_pkg::SPEED_FRAC]};
			end
			S_ABS: begin
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){clock_q[lpc_pkg::CLK_W-1]}}, clock_q};
				op.inv = clock_q[lpc_pkg::CLK_W-1];
				op.cin = clock_q[lpc_pkg::CLK_W-1];
			end
			S_DIV: begin
				op.a   = {{(lpc_pkg::ALU_W-lpc_pkg::DUR_W-1){1'b0}}, rem_q,
					dividend_q[lpc_pkg::CLK_W-1]};
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::DUR_W){1'b0}}, cfg.dur};
				op.inv = 1'b1;
				op.cin = 1'b1;
			end
			S_ITER: begin
				op.a   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){iter_q[lpc_pkg::CLK_W-1]}}, iter_q};
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){1'b0}}, dividend_q};
				op.inv = neg_q;
			end
			S_REM: begin
				op.a   = neg_q ? {{(lpc_pkg::ALU_W-lpc_pkg::DUR_W){1'b0}}, cfg.dur} : '0;
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::DUR_W){1'b0}}, rem_q};
				op.inv = neg_q;
				op.cin = neg_q;
			end
			S_JDIFF: begin
				op.a   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){inew_q[lpc_pkg::CLK_W-1]}}, inew_q};
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){iter_q[lpc_pkg::CLK_W-1]}}, iter_q};
				op.inv = 1'b1;
				op.cin = 1'b1;
			end
			S_JABS: begin
				op.b   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W-1){j_q[lpc_pkg::CLK_W]}}, j_q};
				op.inv = j_q[lpc_pkg::CLK_W];
				op.cin = j_q[lpc_pkg::CLK_W];
			end
			S_MULT: begin
				op.a = {{(lpc_pkg::ALU_W-AccW){1'b0}}, acc_q};
				op.b = mplier_q[0] ? {{(lpc_pkg::ALU_W-AccW){1'b0}}, mcand_q} : '0;
			end
			S_FIN: begin
				op.a   = {{(lpc_pkg::ALU_W-lpc_pkg::CLK_W){clock_q[lpc_pkg::CLK_W-1]}}, clock_q};
				op.b   = {{(lpc_pkg::ALU_W-AccW){1'b0}}, acc_q};
				op.inv = ~jneg_q;
				op.cin = ~jneg_q;
			end
			default: op = '0;
		endcase
	end

	lpc_alu u_alu (
		.op  (op),
		.sum (alu_sum)
	);

	// A restoring step succeeds when the trial difference is not negative.
	assign div_ok = ~alu_sum[lpc_pkg::ALU_W-1];

	// Clamp the new iteration to the limit, or saturate it when looping forever.
	always_comb begin
		inew_c = idx_q[lpc_pkg::CLK_W-1:0];
		mod_c  = 1'b0;
		if (cfg.lim != '0) begin
			if (idx_q[IdxW-1]) begin
				inew_c = '0;
				mod_c  = 1'b1;
			end else if ($signed(idx_q) >= $signed({{(IdxW-lpc_pkg::LIM_W){1'b0}}, cfg.lim}))
			begin
				inew_c = {{(lpc_pkg::CLK_W-lpc_pkg::LIM_W){1'b0}}, cfg.lim - 16'd1};
				mod_c  = 1'b1;
			end
		end else if (idx_q[IdxW-1:lpc_pkg::CLK_W-1] != {(IdxW-lpc_pkg::CLK_W+1){idx_q[IdxW-1]}})
		begin
			inew_c = lpc_pkg::sat32({{(lpc_pkg::ALU_W-IdxW){idx_q[IdxW-1]}}, idx_q});
			mod_c  = 1'b1;
		end
	end

	// Sequencer state and the architectural clock and iteration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			clock_q <= '0;
			iter_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (tick_delta == '0) ? S_DONE : S_ADV;
					end
				end
				S_ADV: begin
					clock_q <= lpc_pkg::sat32(alu_sum);
					state_q <= S_ABS;
				end
				S_ABS: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(DivSteps - 1)) begin
						state_q <= S_ITER;
					end
				end
				S_ITER: state_q <= S_CLAMP;
				S_CLAMP: begin
					if (inew_c == iter_q) begin
						state_q <= S_DONE;
					end else if (!mod_c) begin
						state_q <= S_REM;
					end else begin
						state_q <= S_JDIFF;
					end
				end
				S_REM: begin
					clock_q <= alu_sum[lpc_pkg::CLK_W-1:0];
					iter_q  <= inew_q;
					state_q <= S_DONE;
				end
				S_JDIFF: state_q <= S_JABS;
				S_JABS: begin
					cnt_q   <= '0;
					state_q <= S_MULT;
				end
				S_MULT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(MulSteps - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					clock_q <= lpc_pkg::sat32(alu_sum);
					iter_q  <= inew_q;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (taken) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers of the divider and multiplier.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: prod_q <= prod_c[ProdW-1:0];
			S_ABS: begin
				neg_q      <= clock_q[lpc_pkg::CLK_W-1];
				dividend_q <= alu_sum[lpc_pkg::CLK_W-1:0];
				rem_q      <= '0;
			end
			S_DIV: begin
				rem_q      <= div_ok ? alu_sum[lpc_pkg::DUR_W-1:0]
					: {rem_q[lpc_pkg::DUR_W-2:0], dividend_q[lpc_pkg::CLK_W-1]};
				dividend_q <= {dividend_q[lpc_pkg::CLK_W-2:0], div_ok};
			end
			S_ITER: idx_q <= alu_sum[IdxW-1:0];
			S_CLAMP: inew_q <= inew_c;
			S_JDIFF: j_q <= alu_sum[lpc_pkg::CLK_W:0];
			S_JABS: begin
				jneg_q   <= j_q[lpc_pkg::CLK_W];
				mcand_q  <= {{(AccW-lpc_pkg::CLK_W){1'b0}}, alu_sum[lpc_pkg::CLK_W-1:0]};
				mplier_q <= cfg.dur;
				acc_q    <= '0;
			end
			S_MULT: begin
				acc_q    <= alu_sum[AccW-1:0];
				mcand_q  <= {mcand_q[AccW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[lpc_pkg::DUR_W-1:1]};
			end
			default: ;
		endcase
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.done = (state_q == S_DONE);
	assign clock       = clock_q;
	assign iteration   = iter_q;

endmodule

// File: hw/rtl/looped_playback_clock_top.sv
// Channel   Direction  Handshake            Payload
// tick      in         in_valid, in_stall   tick_delta
// result    out        out_valid, out_stall raw_clock, clamped_clock, iteration_index,
//                                           underflow, overflow
// config    in         cfg_wr               cfg_index, cfg_data
//
// A tick of zero goes from acceptance straight to the done state. Any other tick runs the
// 32-step restoring divider on the shared 65-bit adder, plus a remainder step when the clock
// folds. When the iteration is clamped or saturated, a 31-step shift-add multiply on the same
// adder follows. in_stall is high from acceptance until the result has moved into the output
// register; a waiting tick is taken in the cycle after. Reset is asynchronous and restores
// the sequencer, configuration and valid registers, not the data registers; no clearing pass.
module looped_playback_clock_top #(
	parameter int unsigned CLOCK_FRAC_BITS = lpc_pkg::CLOCK_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [lpc_pkg::DT_W-1:0]          tick_delta,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [lpc_pkg::CLK_W-1:0]  raw_clock,
	output logic [lpc_pkg::DUR_W-1:0]         clamped_clock,
	output logic signed [lpc_pkg::CLK_W-1:0]  iteration_index,
	output logic                              underflow,
	output logic                              overflow,
	input  logic                              cfg_wr,
	input  logic [lpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpc_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [lpc_pkg::DUR_W-1:0] DurReset = lpc_pkg::DUR_W'(1) << CLOCK_FRAC_BITS;

	logic [lpc_pkg::SPEED_W-1:0]  speed_q;
	logic [lpc_pkg::DUR_W-1:0]    dur_q;
	logic [lpc_pkg::LIM_W-1:0]    lim_q;
	logic                         out_valid_q;

	lpc_pkg::cfg_t                cfg;
	lpc_pkg::seq_status_t         status;
	logic [lpc_pkg::CLK_W-1:0]    seq_clock;
	logic [lpc_pkg::CLK_W-1:0]    seq_iter;
	logic                         start;
	logic                         load;
	logic [lpc_pkg::DUR_W-1:0]    clamped_c;
	logic [lpc_pkg::CLK_W:0]      lim_m1;
	logic                         under_c;
	logic                         over_c;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd256;
			dur_q   <= DurReset;
			lim_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				lpc_pkg::REG_SPEED:           speed_q <= cfg_data[lpc_pkg::SPEED_W-1:0];
				lpc_pkg::REG_LOOP_DURATION:   dur_q   <= cfg_data[lpc_pkg::DUR_W-1:0];
				lpc_pkg::REG_ITERATION_LIMIT: lim_q   <= cfg_data[lpc_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// A duration of zero behaves as one.
	assign cfg.speed = speed_q;
	assign cfg.dur   = (dur_q == '0) ? lpc_pkg::DUR_W'(1) : dur_q;
	assign cfg.lim   = lim_q;

	assign in_stall = ~status.idle;
	assign start    = in_valid & ~in_stall;
	assign load     = status.done & (~out_valid_q | ~out_stall);

	lpc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.tick_delta (tick_delta),
		.cfg        (cfg),
		.taken      (load),
		.status     (status),
		.clock      (seq_clock),
		.iteration  (seq_iter)
	);

	// Result fields derived from the final clock and iteration.
	assign lim_m1 = {{(lpc_pkg::CLK_W-lpc_pkg::LIM_W+1){1'b0}}, lim_q} - 33'd1;

	always_comb begin
		if (seq_clock[lpc_pkg::CLK_W-1]) begin
			clamped_c = '0;
		end else if (seq_clock[lpc_pkg::DUR_W-1:0] > cfg.dur) begin
			clamped_c = cfg.dur;
		end else begin
			clamped_c = seq_clock[lpc_pkg::DUR_W-1:0];
		end
		if (lim_q == '0) begin
			under_c = 1'b1;
			over_c  = 1'b1;
		end else begin
			under_c = $signed(seq_iter) > 0;
			over_c  = $signed({seq_iter[lpc_pkg::CLK_W-1], seq_iter}) < $signed(lim_m1);
		end
	end

	// Output register: holds a finished transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			raw_clock       <= seq_clock;
			clamped_clock   <= clamped_c;
			iteration_index <= seq_iter;
			underflow       <= under_c;
			overflow        <= over_c;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: hw/rtl/lpc_checker.sv
`include "assert_macros.svh"

module lpc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [lpc_pkg::CLK_W-1:0]  raw_clock,
	input logic [lpc_pkg::DUR_W-1:0]         clamped_clock,
	input logic signed [lpc_pkg::CLK_W-1:0]  iteration_index
);

	// The block is busy in the cycle after it takes a tick.
	`ASSERT_NXT(a_accept_busy, clk, arst_n, in_valid && !in_stall, in_stall)

	// No result appears in the cycle right after a tick is taken.
	`ASSERT_NXT(a_no_instant_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid))

	// A stalled result transaction stays valid and holds its raw clock and iteration index.
	`ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(raw_clock) && $stable(iteration_index))

	// A negative clock clamps to zero.
	`ASSERT_IMP(a_neg_clamp, clk, arst_n, out_valid && raw_clock[31], clamped_clock == '0)

	// The clamped clock never exceeds a non-negative raw clock.
	`ASSERT_IMP(a_clamp_below, clk, arst_n, out_valid && !raw_clock[31],
		clamped_clock <= raw_clock[30:0])

endmodule

bind looped_playback_clock_top lpc_checker u_lpc_checker (.*);

// File: tb/sv/testbench.sv
module testbench;
	import lpc_pkg::*;

	// Q8.16 tick and Q15.16 duration constants, and run limits, used by the directed tests.
	localparam logic [DT_W-1:0]  TICK_MAX  = '1;
	localparam logic [DT_W-1:0]  TICK_ONE  = 24'd65536;
	localparam logic [DUR_W-1:0] DUR_MAX   = '1;
	localparam logic [DUR_W-1:0] DUR_ONE   = 31'd65536;
	localparam int               HOLD_LEN  = 800;
	localparam int               DRAIN_MAX = 20000;
	localparam int               SETTLE_END = 80;

	// One result of the clock, as the outputs present it.
	typedef struct {
		logic signed [CLK_W-1:0] raw;
		logic [DUR_W-1:0]        clamped;
		logic signed [CLK_W-1:0] iter;
		logic                    under;
		logic                    over;
	} clock_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [DT_W-1:0]         tick_delta = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [CLK_W-1:0] raw_clock;
	logic [DUR_W-1:0]        clamped_clock;
	logic signed [CLK_W-1:0] iteration_index;
	logic                    underflow;
	logic                    overflow;
	logic                    cfg_wr = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;

	// Predicted state and the register copies it runs on.
	longint                  play_clock = 0;
	longint                  play_iter = 0;
	logic signed [SPEED_W-1:0] rate_cfg = 16'sd256;
	logic [DUR_W-1:0]        dur_cfg = DUR_ONE;
	logic [LIM_W-1:0]        limit_cfg = '0;

	clock_result_t           expected_ticks[$];
	int                      sender_idle_pct = 0;
	int                      receiver_stall_pct = 0;
	int                      hold_cycles = 0;
	int                      ticks_sent = 0;
	int                      results_checked = 0;
	int                      settings_used = 0;
	int                      error_count = 0;

	looped_playback_clock_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.tick_delta(tick_delta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.raw_clock(raw_clock),
		.clamped_clock(clamped_clock),
		.iteration_index(iteration_index),
		.underflow(underflow),
		.overflow(overflow),
		.cfg_wr(cfg_wr),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Saturate to the signed 32-bit range.
	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) begin
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// Advance the predicted clock by one tick and fold it into the loop.
	function automatic clock_result_t advance_clock(input logic [DT_W-1:0] dt);
		longint dur, lim, step, q, j, c;
		clock_result_t r;
		dur = longint'(dur_cfg);
		if (dur == 0) begin
			dur = 1;
		end
		lim = longint'(limit_cfg);
		if (dt != '0) begin
			step = (longint'(rate_cfg) * longint'(dt)) >>> SPEED_FRAC;
			play_clock = clip32(play_clock + step);
			// A negative clock always takes one extra step down, even on an exact multiple.
			q = play_iter + play_clock / dur;
			if (play_clock < 0) begin
				q = q - 1;
			end
			if (lim != 0) begin
				if (q < 0) begin
					q = 0;
				end else if (q >= lim) begin
					q = lim - 1;
				end
			end else begin
				q = clip32(q);
			end
			// Only the iterations actually stepped come off the clock.
			j = q - play_iter;
			if (j != 0) begin
				play_iter = q;
				play_clock = clip32(play_clock - j * dur);
			end
		end
		if (play_clock < 0) begin
			c = 0;
		end else if (play_clock > dur) begin
			c = dur;
		end else begin
			c = play_clock;
		end
		r.raw = 32'(play_clock);
		r.clamped = 31'(c);
		r.iter = 32'(play_iter);
		r.under = (lim != 0) ? (play_iter > 0) : 1'b1;
		r.over = (lim != 0) ? (play_iter < lim - 1) : 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Predict on every accepted tick transaction.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_ticks.push_back(advance_clock(tick_delta));
			ticks_sent++;
		end
	end

	// Compare every accepted result transaction with the oldest prediction.
	always @(posedge clk) begin : check_results
		clock_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("result with no tick outstanding");
			end else begin
				want = expected_ticks.pop_front();
				if (raw_clock !== want.raw)
					report_mismatch($sformatf("raw_clock got %h want %h", raw_clock, want.raw));
				if (clamped_clock !== want.clamped)
					report_mismatch($sformatf("clamped_clock got %h want %h",
						clamped_clock, want.clamped));
				if (iteration_index !== want.iter)
					report_mismatch($sformatf("iteration_index got %h want %h",
						iteration_index, want.iter));
				if (underflow !== want.under)
					report_mismatch($sformatf("underflow got %b want %b", underflow, want.under));
				if (overflow !== want.over)
					report_mismatch($sformatf("overflow got %b want %b", overflow, want.over));
				results_checked++;
			end
		end
	end

	// Receiver stalls: a long hold-off when requested, random stalls otherwise.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	// Offer one tick, with a random gap before it, and wait until it is taken.
	task automatic send_tick(input logic [DT_W-1:0] dt);
		if ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		in_valid <= 1'b1;
		tick_delta <= dt;
		do @(posedge clk); while (in_stall !== 1'b0);
	endtask

	// Stop offering ticks and wait for every outstanding result.
	task automatic settle_block(input int extra);
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		// This wait lets the predictor record a transaction taken at this edge.
		@(posedge clk);
		while (expected_ticks.size() != 0 && waited < DRAIN_MAX) begin
			@(posedge clk);
			waited++;
		end
		if (expected_ticks.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
			expected_ticks.delete();
		end
		repeat (extra) @(posedge clk);
	endtask

	// Write all three registers while the block is idle.
	task automatic set_playback(input logic signed [SPEED_W-1:0] spd,
			input logic [DUR_W-1:0] dur, input logic [LIM_W-1:0] lim);
		settle_block(4);
		cfg_wr <= 1'b1;
		cfg_index <= REG_SPEED;
		cfg_data <= {15'($urandom), spd};
		@(posedge clk);
		cfg_index <= REG_LOOP_DURATION;
		cfg_data <= dur;
		@(posedge clk);
		cfg_index <= REG_ITERATION_LIMIT;
		cfg_data <= {15'($urandom), lim};
		@(posedge clk);
		cfg_wr <= 1'b0;
		rate_cfg = spd;
		dur_cfg = dur;
		limit_cfg = lim;
		settings_used++;
	endtask

	function automatic logic signed [SPEED_W-1:0] pick_speed();
		case ($urandom_range(5))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2: return 16'sd256;
			3: return -16'sd256;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [DUR_W-1:0] pick_duration();
		case ($urandom_range(6))
			0: return '0;
			1: return 31'd1;
			2: return DUR_MAX;
			3: return 31'($urandom_range(1, 4096));
			4: return 31'($urandom_range(16384, 262144));
			5: return DUR_ONE;
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic logic [LIM_W-1:0] pick_limit();
		case ($urandom_range(5))
			0, 1: return '0;
			2: return 16'hFFFF;
			3: return 16'($urandom);
			default: return 16'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [DT_W-1:0] pick_tick();
		case ($urandom_range(9))
			0: return '0;
			1: return TICK_MAX;
			2: return 24'($urandom_range(1, 255));
			3: return 24'($urandom_range(1, 131072));
			default: return 24'($urandom);
		endcase
	endfunction

	// Ticks under the register values left by reset.
	task automatic test_reset_defaults();
		send_tick('0);
		send_tick(TICK_ONE);
		send_tick(24'd32768);
		send_tick(24'd1);
		send_tick(TICK_MAX);
	endtask

	// Extreme speeds saturate the clock; zero and unit durations fold a negative clock.
	task automatic test_speed_and_duration_extremes();
		set_playback(-16'sd32768, DUR_MAX, '0);
		send_tick(TICK_MAX);
		send_tick(TICK_MAX);
		set_playback(16'sd32767, DUR_MAX, '0);
		send_tick(TICK_MAX);
		send_tick(TICK_MAX);
		send_tick(TICK_MAX);
		// A negative clock on an exact multiple of the duration folds up to the duration.
		set_playback(-16'sd256, '0, '0);
		send_tick(24'd1);
		send_tick(24'd1);
		send_tick('0);
		send_tick(24'd256);
		set_playback(-16'sd256, 31'd1, '0);
		send_tick(TICK_ONE);
	endtask

	// Clamped iterations leave the clock outside the loop; a stale index is clamped.
	task automatic test_iteration_limits();
		set_playback(16'sd256, DUR_ONE, 16'd1);
		send_tick(TICK_MAX);
		send_tick('0);
		send_tick(24'd1);
		set_playback(-16'sd256, DUR_ONE, 16'd3);
		send_tick(TICK_MAX);
		send_tick(TICK_ONE);
		set_playback(16'sd32767, 31'd1, '0);
		send_tick(TICK_MAX);
		set_playback(16'sd256, DUR_ONE, 16'hFFFF);
		send_tick(24'd1);
		set_playback(16'sd256, DUR_ONE, 16'd2);
		send_tick(24'd1);
	endtask

	// Random ticks under a new random setting every fifty transactions.
	task automatic test_random_ticks(input int idle_pct, input int stall_pct, input int count);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				set_playback(pick_speed(), pick_duration(), pick_limit());
			end
			send_tick(pick_tick());
		end
		settle_block(4);
	endtask

	// Hold the output off while ticks keep coming, so the input backs up.
	task automatic test_output_hold_off();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		set_playback(pick_speed(), 31'($urandom_range(1, 262144)), pick_limit());
		hold_cycles = HOLD_LEN;
		repeat (30) send_tick(pick_tick());
		settle_block(4);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_speed_and_duration_extremes();
		test_iteration_limits();
		test_random_ticks(0, 0, 300);
		test_random_ticks(53, 0, 300);
		test_random_ticks(0, 53, 300);
		test_random_ticks(25, 25, 300);
		test_output_hold_off();
		settle_block(SETTLE_END);
		$display("Covered %0d ticks over %0d register settings, four idling mixes and",
			ticks_sent, settings_used);
		$display("a long output hold-off; %0d results compared, %0d mismatches.",
			results_checked, error_count);
		if (error_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#(20 * 1000000);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
